[sv/pmdpl_pkg.sv]
package pmdpl_pkg;

  typedef enum logic [1:0] {
    OP_POLL   = 2'd0,
    OP_QUERY  = 2'd1,
    OP_SET_LATCH = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_TIMEOUT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PICKUP_MIN     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PICKUP_MAX     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LOCKED  = 3'd4;

  localparam logic [7:0]  MOVE_THRESHOLD_RST = 8'd2;
  localparam logic [15:0] MOVE_TIMEOUT_RST   = 16'd100;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] sample;
    logic [7:0] ticks_elapsed;
    logic       latch_enable;
  } in_item_t;

  typedef struct packed {
    logic       moving_started;
    logic       moving_stopped;
    logic       latch_event;
    logic       latched_now;
    logic       value_event;
    logic [7:0] output_value;
    logic       value_changed;
  } out_item_t;

endpackage

[sv/pot_move_detect_pickup_latch.sv]
// Knob sample qualifier with movement detection and pickup latching. Each
// input item (poll, query, set-latching or unused) yields exactly one result item.
// An item is processed in the cycle it is accepted and its result appears in
// the output register on the next cycle; a new item is taken every cycle as
// long as the output register is empty or being drained, so the sustained
// rate is one item per clock. Configuration registers are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no item is in
// flight, unenforced by the block; indexes past the last register are ignored.
module pot_move_detect_pickup_latch (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  pmdpl_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pmdpl_pkg::out_item_t                 out_item,
  input  logic                                 cfg_we,
  input  logic [pmdpl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pmdpl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pmdpl_pkg::*;

  // configuration
  logic [7:0]  move_threshold;
  logic [15:0] move_timeout;
  logic [7:0]  pickup_min;
  logic [7:0]  pickup_max;
  logic        output_locked;

  // block state
  logic [7:0]  last_accepted, last_accepted_next;
  logic [7:0]  out_value, out_value_next;
  logic        moving, moving_next;
  logic [15:0] move_ticks, move_ticks_next;
  logic        latching_mode, latching_mode_next;
  logic        latched, latched_next;

  out_item_t   result_next;
  logic        in_fire;

  logic [7:0]  jump;
  logic [16:0] tick_sum;
  logic [15:0] tick_sat;
  logic        start, stop, take_sample, crossing, in_window;
  logic        track;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold <= MOVE_THRESHOLD_RST;
      move_timeout   <= MOVE_TIMEOUT_RST;
      pickup_min     <= '0;
      pickup_max     <= '0;
      output_locked  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOVE_THRESHOLD: move_threshold <= cfg_data[7:0];
        REG_MOVE_TIMEOUT:   move_timeout   <= cfg_data;
        REG_PICKUP_MIN:     pickup_min     <= cfg_data[7:0];
        REG_PICKUP_MAX:     pickup_max     <= cfg_data[7:0];
        REG_OUTPUT_LOCKED:  output_locked  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    jump = (in_item.sample >= last_accepted) ? in_item.sample - last_accepted
                                             : last_accepted - in_item.sample;
    tick_sum = {1'b0, move_ticks} + {9'd0, in_item.ticks_elapsed};
    tick_sat = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
    in_window = (out_value >= pickup_min) && (out_value <= pickup_max);
    crossing = ((in_item.sample >= pickup_min) && (last_accepted <= pickup_min)) ||
               ((in_item.sample <= pickup_max) && (last_accepted >= pickup_max));

    track = (in_item.opcode == OP_POLL) || (in_item.opcode == OP_QUERY);

    last_accepted_next = last_accepted;
    out_value_next     = out_value;
    moving_next        = moving;
    move_ticks_next    = move_ticks;
    latching_mode_next = latching_mode;
    latched_next       = latched;
    start              = 1'b0;
    stop               = 1'b0;

    // movement tracking shared by poll and query
    if (track) begin
      if ((jump > move_threshold) && !moving) begin
        start           = 1'b1;
        moving_next     = 1'b1;
        move_ticks_next = '0;
      end else if (moving) begin
        move_ticks_next = tick_sat;
        if (tick_sat >= move_timeout) begin
          stop        = 1'b1;
          moving_next = 1'b0;
        end
      end
    end
    take_sample = track && moving_next && (in_item.sample != last_accepted);

    result_next = '0;
    unique case (opcode_t'(in_item.opcode))
      OP_POLL: begin
        result_next.moving_started = start;
        result_next.moving_stopped = stop;
        if (take_sample) begin
          if (!output_locked && latching_mode && !latched && crossing) begin
            latched_next            = 1'b1;
            result_next.latch_event = 1'b1;
          end
          last_accepted_next = in_item.sample;
          if (!output_locked) begin
            out_value_next          = in_item.sample;
            result_next.value_event = 1'b1;
          end
        end
      end
      OP_QUERY: begin
        if (take_sample) begin
          last_accepted_next        = in_item.sample;
          result_next.value_changed = 1'b1;
        end
      end
      OP_SET_LATCH: begin
        latching_mode_next      = in_item.latch_enable;
        latched_next            = in_item.latch_enable ? in_window : 1'b1;
        result_next.latch_event = (latched_next != latched);
      end
      default: ;
    endcase
    result_next.latched_now  = latched_next;
    result_next.output_value = out_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accepted <= '0;
      out_value     <= '0;
      moving        <= 1'b0;
      move_ticks    <= '0;
      latching_mode <= 1'b0;
      latched       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        last_accepted <= last_accepted_next;
        out_value     <= out_value_next;
        moving        <= moving_next;
        move_ticks    <= move_ticks_next;
        latching_mode <= latching_mode_next;
        latched       <= latched_next;
      end
      // hold the result until taken
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item <= result_next;
    end
  end

endmodule

[sv/pmdpl_checker.sv]
module pmdpl_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  pmdpl_pkg::out_item_t  out_item
);
  import pmdpl_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // every accepted item produces a result on the next cycle
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.moving_started && out_item.moving_stopped) &&
                  !(out_item.value_event && out_item.value_changed))
    else $error("conflicting result flags");

  // the input side never stalls while the output side drains
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output register");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pot_move_detect_pickup_latch pmdpl_checker u_pmdpl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

[dv/pot_move_detect_pickup_latch_tb.sv]
`timescale 1ns / 100ps

module pot_move_detect_pickup_latch_tb;
  import pmdpl_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET = 1350;

  typedef enum int {MOTION_NONE, MOTION_START, MOTION_STOP} motion_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_item;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predicted knob state and register copies
  logic [7:0]  set_threshold;
  logic [15:0] set_timeout;
  logic [7:0]  win_min;
  logic [7:0]  win_max;
  logic        out_locked;
  logic [7:0]  knob_last;
  logic [7:0]  knob_out;
  logic        knob_moving;
  logic [15:0] knob_ticks;
  logic        knob_lmode;
  logic        knob_latched;

  out_item_t   pending_results[$];
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned items_sent;
  int unsigned useful_items;
  int unsigned settings_used;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned seen_starts;
  int unsigned seen_stops;
  int unsigned seen_latch_events;
  int unsigned seen_value_events;
  int unsigned seen_changes;

  pot_move_detect_pickup_latch u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic motion_t track_knob(logic [7:0] smp, logic [7:0] te);
    logic [7:0]  jump;
    logic [16:0] sum;
    jump = (smp >= knob_last) ? smp - knob_last : knob_last - smp;
    if (jump > set_threshold && !knob_moving) begin
      knob_moving = 1'b1;
      knob_ticks = '0;
      return MOTION_START;
    end
    if (knob_moving) begin
      sum = {1'b0, knob_ticks} + {9'd0, te};
      knob_ticks = sum[16] ? 16'hFFFF : sum[15:0];
      if (knob_ticks >= set_timeout) begin
        knob_moving = 1'b0;
        return MOTION_STOP;
      end
    end
    return MOTION_NONE;
  endfunction

  function automatic out_item_t predict_knob(in_item_t it);
    out_item_t r;
    motion_t   m;
    logic      nl;
    r = '0;
    case (opcode_t'(it.opcode))
      OP_POLL: begin
        m = track_knob(it.sample, it.ticks_elapsed);
        r.moving_started = (m == MOTION_START);
        r.moving_stopped = (m == MOTION_STOP);
        if (knob_moving && it.sample != knob_last) begin
          if (!out_locked && knob_lmode && !knob_latched &&
              ((it.sample >= win_min && knob_last <= win_min) ||
               (it.sample <= win_max && knob_last >= win_max))) begin
            knob_latched = 1'b1;
            r.latch_event = 1'b1;
          end
          knob_last = it.sample;
          if (!out_locked) begin
            knob_out = it.sample;
            r.value_event = 1'b1;
          end
        end
      end
      OP_QUERY: begin
        m = track_knob(it.sample, it.ticks_elapsed);
        if (knob_moving && it.sample != knob_last) begin
          knob_last = it.sample;
          r.value_changed = 1'b1;
        end
      end
      OP_SET_LATCH: begin
        knob_lmode = it.latch_enable;
        nl = !knob_lmode ? 1'b1 : (knob_out >= win_min && knob_out <= win_max);
        if (nl != knob_latched) begin
          knob_latched = nl;
          r.latch_event = 1'b1;
        end
      end
      default: ;
    endcase
    r.latched_now = knob_latched;
    r.output_value = knob_out;
    return r;
  endfunction

  function automatic in_item_t knob_item(opcode_t op, logic [7:0] smp, logic [7:0] te,
                                         logic en);
    in_item_t it;
    it.opcode = op;
    it.sample = smp;
    it.ticks_elapsed = te;
    it.latch_enable = en;
    return it;
  endfunction

  function automatic string fmt_result(out_item_t r);
    return $sformatf("start=%b stop=%b lev=%b latched=%b vev=%b out=%0d chg=%b",
                     r.moving_started, r.moving_stopped, r.latch_event, r.latched_now,
                     r.value_event, r.output_value, r.value_changed);
  endfunction

  task automatic send_knob(input in_item_t it);
    int unsigned gap;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_knob(it));
    items_sent++;
    if (it.opcode != OP_UNUSED) useful_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        9:       gap = $urandom_range(10, 20);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off until every expected result is back and the pipeline is empty
  task automatic drain_knob();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_knob(input logic [7:0] thr, input logic [15:0] tmo,
                              input logic [7:0] lo, input logic [7:0] hi, input logic lock);
    cfg_we <= 1'b1;
    cfg_index <= REG_MOVE_THRESHOLD;
    cfg_data <= {8'($urandom()), thr};
    @(posedge clk);
    cfg_index <= REG_MOVE_TIMEOUT;
    cfg_data <= tmo;
    @(posedge clk);
    cfg_index <= REG_PICKUP_MIN;
    cfg_data <= {8'($urandom()), lo};
    @(posedge clk);
    cfg_index <= REG_PICKUP_MAX;
    cfg_data <= {8'($urandom()), hi};
    @(posedge clk);
    cfg_index <= REG_OUTPUT_LOCKED;
    cfg_data <= {15'($urandom()), lock};
    @(posedge clk);
    cfg_we <= 1'b0;
    set_threshold = thr;
    set_timeout = tmo;
    win_min = lo;
    win_max = hi;
    out_locked = lock;
    settings_used++;
  endtask

  function automatic in_item_t random_knob_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.opcode = (pick < 55) ? OP_POLL : (pick < 75) ? OP_QUERY :
                (pick < 90) ? OP_SET_LATCH : OP_UNUSED;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.sample = knob_last + 8'($urandom_range(0, 12)) - 8'd6;
      4:          it.sample = win_min + 8'($urandom_range(0, 4)) - 8'd2;
      5:          it.sample = win_max + 8'($urandom_range(0, 4)) - 8'd2;
      6:          it.sample = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default:    it.sample = 8'($urandom_range(0, 255));
    endcase
    pick = $urandom_range(0, 19);
    it.ticks_elapsed = (pick < 14) ? 8'($urandom_range(0, 3)) :
                       (pick < 19) ? 8'($urandom_range(0, 255)) : 8'd255;
    it.latch_enable = ($urandom_range(0, 3) != 0);
    return it;
  endfunction

  // re-arm the latch, then ramp the knob from a random spot toward a window bound
  task automatic sweep_knob();
    logic [7:0] bound_v;
    int         from, to, steps, i;
    bound_v = $urandom_range(0, 1) ? win_min : win_max;
    from = $urandom_range(0, 255);
    to = int'(bound_v) + int'($urandom_range(0, 40)) - 20;
    if (to < 0) to = 0;
    if (to > 255) to = 255;
    steps = $urandom_range(3, 12);
    send_knob(knob_item(OP_SET_LATCH, 8'($urandom()), 8'($urandom_range(0, 3)), 1'b1));
    for (i = 0; i <= steps; i++)
      send_knob(knob_item(OP_POLL, 8'(from + (to - from) * i / steps),
                          8'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
  endtask

  task automatic test_directed();
    // defaults after reset: threshold 2, timeout 100, window 0..0, unlocked
    send_knob(knob_item(OP_UNUSED, 8'd255, 8'd255, 1'b1));
    send_knob(knob_item(OP_QUERY, 8'd2, 8'd0, 1'b0));
    send_knob(knob_item(OP_POLL, 8'd3, 8'd0, 1'b0));
    send_knob(knob_item(OP_QUERY, 8'd255, 8'd255, 1'b0));
    send_knob(knob_item(OP_POLL, 8'd0, 8'd0, 1'b0));
    send_knob(knob_item(OP_QUERY, 8'd128, 8'd1, 1'b0));
    send_knob(knob_item(OP_SET_LATCH, 8'd0, 8'd0, 1'b1));
    send_knob(knob_item(OP_SET_LATCH, 8'd0, 8'd0, 1'b0));
    drain_knob();
    // zero timeout: every movement ends on the next item
    program_knob(8'd0, 16'd0, 8'd100, 8'd200, 1'b0);
    send_knob(knob_item(OP_SET_LATCH, 8'd255, 8'd0, 1'b1));
    send_knob(knob_item(OP_POLL, 8'd50, 8'd0, 1'b0));
    send_knob(knob_item(OP_POLL, 8'd150, 8'd0, 1'b0));
    send_knob(knob_item(OP_POLL, 8'd90, 8'd0, 1'b0));
    send_knob(knob_item(OP_POLL, 8'd90, 8'd0, 1'b0));
    send_knob(knob_item(OP_POLL, 8'd150, 8'd0, 1'b0));
    send_knob(knob_item(OP_POLL, 8'd150, 8'd0, 1'b0));
    drain_knob();
    // locked output, inverted window
    program_knob(8'd0, 16'd0, 8'd255, 8'd0, 1'b1);
    send_knob(knob_item(OP_SET_LATCH, 8'd0, 8'd0, 1'b1));
    send_knob(knob_item(OP_POLL, 8'd0, 8'd0, 1'b0));
    send_knob(knob_item(OP_POLL, 8'd0, 8'd0, 1'b0));
    send_knob(knob_item(OP_POLL, 8'd77, 8'd0, 1'b1));
    send_knob(knob_item(OP_QUERY, 8'd255, 8'd255, 1'b1));
    drain_knob();
  endtask

  // tick count runs into saturation at the largest timeout
  task automatic test_long_move();
    int i;
    program_knob(8'd0, 16'hFFFF, 8'd20, 8'd230, 1'b0);
    send_knob(knob_item(OP_POLL, knob_last ^ 8'h80, 8'd0, 1'b0));
    for (i = 0; i < 280; i++)
      send_knob(knob_item(($urandom_range(0, 4) == 0) ? OP_QUERY : OP_POLL,
                          8'($urandom_range(0, 255)), 8'($urandom_range(240, 255)), 1'b0));
    drain_knob();
  endtask

  task automatic test_random_phases();
    int          phase;
    int unsigned actions, pick;
    logic [7:0]  thr, lo, hi, tmp;
    logic [15:0] tmo;
    phase = 0;
    while (useful_items < ITEM_TARGET) begin
      case (phase)
        0: program_knob(8'd0, 16'd0, 8'd0, 8'd0, 1'b0);
        1: program_knob(8'd255, 16'hFFFF, 8'd255, 8'd255, 1'b1);
        2: program_knob(8'd1, 16'hFFFF, 8'd0, 8'd255, 1'b0);
        default: begin
          pick = $urandom_range(0, 9);
          thr = (pick < 5) ? 8'($urandom_range(0, 4)) : (pick < 8) ? 8'($urandom_range(0, 40)) :
                (pick == 8) ? 8'd0 : 8'd255;
          pick = $urandom_range(0, 9);
          tmo = (pick < 4) ? 16'($urandom_range(1, 60)) :
                (pick < 7) ? 16'($urandom_range(60, 2000)) :
                (pick == 7) ? 16'd0 : (pick == 8) ? 16'hFFFF : 16'($urandom());
          lo = 8'($urandom_range(0, 255));
          hi = 8'($urandom_range(0, 255));
          if (lo > hi && $urandom_range(0, 9) < 7) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
          end
          program_knob(thr, tmo, lo, hi, $urandom_range(0, 4) == 0);
        end
      endcase
      // the latch is re-armed right after the register writes
      send_knob(knob_item(OP_SET_LATCH, 8'($urandom()), 8'($urandom()), 1'b1));
      actions = $urandom_range(40, 70);
      repeat (actions) begin
        if ($urandom_range(0, 3) == 0) sweep_knob();
        else send_knob(random_knob_item());
      end
      drain_knob();
      phase++;
    end
  endtask

  initial begin : rx_stall
    int unsigned mode, seg;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      seg = $urandom_range(40, 300);
      repeat (seg) begin
        @(posedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %s", fmt_result(out_item));
      end else begin
        want = pending_results.pop_front();
        seen_starts += 32'(want.moving_started);
        seen_stops += 32'(want.moving_stopped);
        seen_latch_events += 32'(want.latch_event);
        seen_value_events += 32'(want.value_event);
        seen_changes += 32'(want.value_changed);
        if (out_item.moving_started !== want.moving_started ||
            out_item.moving_stopped !== want.moving_stopped ||
            out_item.latch_event !== want.latch_event ||
            out_item.latched_now !== want.latched_now ||
            out_item.value_event !== want.value_event ||
            out_item.output_value !== want.output_value ||
            out_item.value_changed !== want.value_changed) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d", results_checked);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(out_item));
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    set_threshold = MOVE_THRESHOLD_RST;
    set_timeout = MOVE_TIMEOUT_RST;
    win_min = '0;
    win_max = '0;
    out_locked = 1'b0;
    knob_last = '0;
    knob_out = '0;
    knob_moving = 1'b0;
    knob_ticks = '0;
    knob_lmode = 1'b0;
    knob_latched = 1'b0;
    items_sent = 0;
    useful_items = 0;
    settings_used = 1;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_long_move();
    test_random_phases();
    drain_knob();
    repeat (5) @(posedge clk);
    $display("Ran %0d items (%0d not ignored) under %0d register settings, %0d results checked",
             items_sent, useful_items, settings_used, results_checked);
    $display("Movement starts %0d, stops %0d, latch changes %0d, output updates %0d, changes %0d",
             seen_starts, seen_stops, seen_latch_events, seen_value_events, seen_changes);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/pmdpl_pkg.sv
sv/pot_move_detect_pickup_latch.sv
sv/pmdpl_checker.sv
dv/pot_move_detect_pickup_latch_tb.sv
